>>> design/bms_can_status_decoder_top_defines.svh
// Assertion macros shared by the checker of the battery status decoder.
`ifndef BMS_CAN_STATUS_DECODER_TOP_DEFINES_SVH
`define BMS_CAN_STATUS_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define BCSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define BCSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/bcsd_pkg.sv
// Shared constants, register codes and control types of the battery status decoder.
package bcsd_pkg;

  // Field widths.
  localparam int ID_W       = 11;
  localparam int PWR_W      = 20;
  localparam int RAMP_W     = 14;
  localparam int SOC_PPTT_W = 15;
  localparam int REM_W      = 22;
  localparam int TEMP_W     = 13;
  localparam int EV_W       = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Shared multiplier product and divider dividend width.
  localparam int DIV_W      = PWR_W + SOC_PPTT_W;
  localparam int DVSR_W     = 14;
  localparam int STEP_CNT_W = $clog2(DIV_W);

  // Remaining energy is charge percent times capacity over one hundred. The division by one
  // hundred multiplies by 2^35 / 100 rounded up, which is exact for products below 2^28.
  localparam int                 REM_PROD_W  = 28;
  localparam int                 RECIP_W     = 29;
  localparam int                 RECIP_SHIFT = 35;
  localparam int                 REM_MUL_W   = REM_PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_100   = 29'd343597384;

  // Decoded frame identifiers.
  localparam logic [ID_W-1:0] ID_STATUS = 11'h2F4;
  localparam logic [ID_W-1:0] ID_CELLS  = 11'h4F4;
  localparam logic [ID_W-1:0] ID_TEMPS  = 11'h5F4;
  localparam logic [ID_W-1:0] ID_ALARMS = 11'h7F4;

  // Decoding and scaling constants.
  localparam logic [15:0]       CUR_OFFSET  = 16'd4000;
  localparam logic [8:0]        TEMP_OFFSET = 9'd50;
  localparam logic [DVSR_W-1:0] TOP_SOC     = 14'd9900;
  localparam logic [DVSR_W-1:0] FULL_PPTT   = 14'd10000;
  localparam logic [6:0]        PCT_TO_PPTT = 7'd100;
  localparam logic [1:0]        LVL_MASK    = 2'b11;

  // Low bit of each two-bit alarm level in the alarm word.
  localparam int LVL_CELL_OV = 0;
  localparam int LVL_CELL_UV = 2;
  localparam int LVL_PACK_OV = 4;
  localparam int LVL_PACK_UV = 6;
  localparam int LVL_DIS_OC  = 10;
  localparam int LVL_CHG_OC  = 12;
  localparam int LVL_OVER_T  = 14;
  localparam int LVL_UNDER_T = 16;

  // Event flag bit positions.
  localparam int EV_OV      = 0;
  localparam int EV_UV      = 1;
  localparam int EV_OVER_T  = 2;
  localparam int EV_UNDER_T = 3;
  localparam int EV_CHG_OC  = 4;
  localparam int EV_DIS_OC  = 5;

  // Register reset values.
  localparam logic [PWR_W-1:0]  CAPACITY_RESET    = 20'd30000;
  localparam logic [PWR_W-1:0]  CHG_OVR_RESET     = 20'd10000;
  localparam logic [PWR_W-1:0]  DIS_OVR_RESET     = 20'd10000;
  localparam logic [RAMP_W-1:0] RAMPDOWN_RESET    = 14'd9000;
  localparam logic [PWR_W-1:0]  TOP_BALANCE_RESET = 20'd250;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY     = 3'd0,
    REG_CHG_OVERRIDE = 3'd1,
    REG_DIS_OVERRIDE = 3'd2,
    REG_RAMPDOWN     = 3'd3,
    REG_TOP_BALANCE  = 3'd4
  } cfg_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_frame;
    logic prep;
    logic mul_rem;
    logic mul_ramp;
    logic div_step;
    logic store_rem;
    logic store_ramp;
    logic publish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_ramp;
  } sts_t;

endpackage

>>> design/bcsd_if.sv
// Frame, status and configuration channel interfaces of the battery status decoder.
interface bcsd_frame_if;
  import bcsd_pkg::*;

  logic            valid;
  logic            ready;
  logic [ID_W-1:0] frame_id;
  logic [7:0]      byte0;
  logic [7:0]      byte1;
  logic [7:0]      byte2;
  logic [7:0]      byte3;
  logic [7:0]      byte4;
  logic [7:0]      byte5;
  logic [7:0]      byte6;
  logic [7:0]      byte7;

  modport source (
    output valid, frame_id, byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7,
    input  ready
  );
  modport sink (
    input  valid, frame_id, byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7,
    output ready
  );
endinterface

interface bcsd_status_if;
  import bcsd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [SOC_PPTT_W-1:0]    soc_pptt;
  logic [REM_W-1:0]         remaining_wh;
  logic [15:0]              pack_volt_dv;
  logic signed [16:0]       pack_cur_da;
  logic [PWR_W-1:0]         charge_limit_w;
  logic [PWR_W-1:0]         discharge_limit_w;
  logic signed [TEMP_W-1:0] temp_max_dc;
  logic signed [TEMP_W-1:0] temp_min_dc;
  logic [15:0]              cell_max_mv;
  logic [15:0]              cell_min_mv;
  logic                     fault;
  logic [EV_W-1:0]          event_flags;

  modport source (
    output valid, soc_pptt, remaining_wh, pack_volt_dv, pack_cur_da, charge_limit_w,
           discharge_limit_w, temp_max_dc, temp_min_dc, cell_max_mv, cell_min_mv,
           fault, event_flags,
    input  ready
  );
  modport sink (
    input  valid, soc_pptt, remaining_wh, pack_volt_dv, pack_cur_da, charge_limit_w,
           discharge_limit_w, temp_max_dc, temp_min_dc, cell_max_mv, cell_min_mv,
           fault, event_flags,
    output ready
  );
endinterface

interface bcsd_cfg_if;
  import bcsd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/bms_can_status_decoder_top.sv
// Top level of the battery status decoder fed by received CAN frames.
// A frame is taken only while idle, so the next frame waits until the previous result is published;
// when the charge ramp applies, the 35-step serial divider runs before the result is published.
// A finished result waits in the output register while the next frame is taken; a new result
// is loaded only once the previous transaction completes, so output stalls delay the next frame.
// Reset (rst, synchronous) clears the decoded state, loads register defaults, empties the output.
module bms_can_status_decoder_top (
  input logic          clk,
  input logic          rst,
  bcsd_frame_if.sink   frame,
  bcsd_status_if.source status,
  bcsd_cfg_if.sink     cfg
);
  import bcsd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Configuration writes are taken whenever the block is out of reset.
  assign cfg.ready = !rst;

  bcsd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame.valid),
    .frame_ready  (frame.ready),
    .status_valid (status.valid),
    .status_ready (status.ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  bcsd_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg.valid),
    .cfg_index         (cfg.index),
    .cfg_data          (cfg.data),
    .frame_id          (frame.frame_id),
    .byte0             (frame.byte0),
    .byte1             (frame.byte1),
    .byte2             (frame.byte2),
    .byte3             (frame.byte3),
    .byte4             (frame.byte4),
    .soc_pptt          (status.soc_pptt),
    .remaining_wh      (status.remaining_wh),
    .pack_volt_dv      (status.pack_volt_dv),
    .pack_cur_da       (status.pack_cur_da),
    .charge_limit_w    (status.charge_limit_w),
    .discharge_limit_w (status.discharge_limit_w),
    .temp_max_dc       (status.temp_max_dc),
    .temp_min_dc       (status.temp_min_dc),
    .cell_max_mv       (status.cell_max_mv),
    .cell_min_mv       (status.cell_min_mv),
    .fault             (status.fault),
    .event_flags       (status.event_flags)
  );

endmodule

>>> design/bcsd_ctrl.sv
// Controller state machine that sequences decode, multiply, divide and publish.
module bcsd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           frame_valid,
  output logic           frame_ready,
  output logic           status_valid,
  input  logic           status_ready,
  output bcsd_pkg::cmd_t cmd,
  input  bcsd_pkg::sts_t sts
);
  import bcsd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_MUL_REM,
    S_STORE_REM,
    S_MUL_RAMP,
    S_DIV_RAMP,
    S_STORE_RAMP,
    S_PUBLISH
  } state_t;

  localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(DIV_W - 1);

  state_t                state;
  logic [STEP_CNT_W-1:0] step_cnt;
  logic                  publish_ok;

  // The output register can take a new result once it is empty or being drained.
  assign publish_ok  = !status_valid || status_ready;
  assign frame_ready = (state == S_IDLE) && !rst;

  // Commands decoded from the current state.
  always_comb begin
    cmd            = '0;
    cmd.load_frame = (state == S_IDLE) && frame_valid;
    cmd.prep       = (state == S_PREP);
    cmd.mul_rem    = (state == S_MUL_REM);
    cmd.mul_ramp   = (state == S_MUL_RAMP);
    cmd.div_step   = (state == S_DIV_RAMP);
    cmd.store_rem  = (state == S_STORE_REM);
    cmd.store_ramp = (state == S_STORE_RAMP);
    cmd.publish    = (state == S_PUBLISH) && publish_ok;
  end

  // State, step counter and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step_cnt     <= '0;
      status_valid <= 1'b0;
    end else begin
      // A published result fills the output register; a completed transaction empties it.
      if (cmd.publish) begin
        status_valid <= 1'b1;
      end else if (status_valid && status_ready) begin
        status_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (frame_valid) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          state <= S_MUL_REM;
        end
        S_MUL_REM: begin
          state <= S_STORE_REM;
        end
        S_STORE_REM: begin
          state <= sts.need_ramp ? S_MUL_RAMP : S_PUBLISH;
        end
        S_MUL_RAMP: begin
          step_cnt <= '0;
          state    <= S_DIV_RAMP;
        end
        S_DIV_RAMP: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == STEP_LAST) begin
            state <= S_STORE_RAMP;
          end
        end
        S_STORE_RAMP: begin
          state <= S_PUBLISH;
        end
        S_PUBLISH: begin
          if (publish_ok) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/bcsd_dp.sv
// Datapath: register file, frame decode, shared multiplier, serial divider and result register.
module bcsd_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  bcsd_pkg::cmd_t                        cmd,
  output bcsd_pkg::sts_t                        sts,
  input  logic                                  cfg_we,
  input  logic [bcsd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bcsd_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [bcsd_pkg::ID_W-1:0]             frame_id,
  input  logic [7:0]                            byte0,
  input  logic [7:0]                            byte1,
  input  logic [7:0]                            byte2,
  input  logic [7:0]                            byte3,
  input  logic [7:0]                            byte4,
  output logic [bcsd_pkg::SOC_PPTT_W-1:0]       soc_pptt,
  output logic [bcsd_pkg::REM_W-1:0]            remaining_wh,
  output logic [15:0]                           pack_volt_dv,
  output logic signed [16:0]                    pack_cur_da,
  output logic [bcsd_pkg::PWR_W-1:0]            charge_limit_w,
  output logic [bcsd_pkg::PWR_W-1:0]            discharge_limit_w,
  output logic signed [bcsd_pkg::TEMP_W-1:0]    temp_max_dc,
  output logic signed [bcsd_pkg::TEMP_W-1:0]    temp_min_dc,
  output logic [15:0]                           cell_max_mv,
  output logic [15:0]                           cell_min_mv,
  output logic                                  fault,
  output logic [bcsd_pkg::EV_W-1:0]             event_flags
);
  import bcsd_pkg::*;

  // Raw byte minus the offset, times ten, as a signed temperature.
  function automatic logic signed [TEMP_W-1:0] decode_temp(input logic [7:0] raw);
    logic signed [TEMP_W-1:0] t;
    t = $signed({5'b0, raw}) - $signed({4'b0, TEMP_OFFSET});
    return (t <<< 3) + (t <<< 1);
  endfunction

  // Configuration registers.
  logic [PWR_W-1:0]  capacity_wh;
  logic [PWR_W-1:0]  charge_power_override_w;
  logic [PWR_W-1:0]  discharge_power_override_w;
  logic [RAMP_W-1:0] rampdown_soc_pptt;
  logic [PWR_W-1:0]  top_balance_power_w;

  // Decoded pack state.
  logic [15:0]              pack_voltage;
  logic [15:0]              pack_current;
  logic [7:0]               soc_pct;
  logic [15:0]              cell_high_mv;
  logic [15:0]              cell_low_mv;
  logic signed [TEMP_W-1:0] temp_high;
  logic signed [TEMP_W-1:0] temp_low;
  logic [31:0]              alarm_word;

  // Working registers for the result under computation.
  logic [SOC_PPTT_W-1:0] soc_work;
  logic [REM_W-1:0]      remaining_work;
  logic [PWR_W-1:0]      charge_work;
  logic                  need_ramp;

  // Divider registers: the dividend shifts out at the top while quotient bits enter below.
  logic [DIV_W-1:0]  div_acc;
  logic [DVSR_W-1:0] div_part;
  logic [DVSR_W-1:0] divisor;

  logic [15:0]              cur_raw;
  logic [SOC_PPTT_W-1:0]    soc_pptt_c;
  logic                     cell_ov, cell_uv, pack_ov, pack_uv;
  logic                     dis_oc, chg_oc, over_t, under_t;
  logic                     chg_block, dis_block;
  logic [PWR_W-1:0]         mul_a;
  logic [SOC_PPTT_W-1:0]    mul_b;
  logic [DIV_W-1:0]         mul_p;
  logic [REM_MUL_W-1:0]     rem_scaled;
  logic [DVSR_W:0]          trial;
  logic                     trial_ge;
  logic [DVSR_W:0]          trial_diff;
  logic signed [16:0]       cur_neg;
  logic [EV_W-1:0]          ev_c;

  assign sts.need_ramp = need_ramp;

  // Configuration writes; indexes beyond the register list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_wh                <= CAPACITY_RESET;
      charge_power_override_w    <= CHG_OVR_RESET;
      discharge_power_override_w <= DIS_OVR_RESET;
      rampdown_soc_pptt          <= RAMPDOWN_RESET;
      top_balance_power_w        <= TOP_BALANCE_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CAPACITY:     capacity_wh                <= cfg_data[PWR_W-1:0];
        REG_CHG_OVERRIDE: charge_power_override_w    <= cfg_data[PWR_W-1:0];
        REG_DIS_OVERRIDE: discharge_power_override_w <= cfg_data[PWR_W-1:0];
        REG_RAMPDOWN:     rampdown_soc_pptt          <= cfg_data[RAMP_W-1:0];
        REG_TOP_BALANCE:  top_balance_power_w        <= cfg_data[PWR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Frame decode into the kept state; unknown identifiers change nothing.
  assign cur_raw = {byte3, byte2} - CUR_OFFSET;

  always_ff @(posedge clk) begin
    if (rst) begin
      pack_voltage <= '0;
      pack_current <= '0;
      soc_pct      <= '0;
      cell_high_mv <= '0;
      cell_low_mv  <= '0;
      temp_high    <= '0;
      temp_low     <= '0;
      alarm_word   <= '0;
    end else if (cmd.load_frame) begin
      case (frame_id)
        ID_STATUS: begin
          pack_voltage <= {byte1, byte0};
          pack_current <= cur_raw;
          soc_pct      <= byte4;
        end
        ID_CELLS: begin
          cell_high_mv <= {byte1, byte0};
          cell_low_mv  <= {byte4, byte3};
        end
        ID_TEMPS: begin
          temp_high <= decode_temp(byte0);
          temp_low  <= decode_temp(byte2);
        end
        ID_ALARMS: begin
          alarm_word <= {byte3, byte2, byte1, byte0};
        end
        default: begin
        end
      endcase
    end
  end

  // Alarm levels: a level counts when either of its two bits is set.
  assign cell_ov = |(alarm_word[LVL_CELL_OV +: 2] & LVL_MASK);
  assign cell_uv = |(alarm_word[LVL_CELL_UV +: 2] & LVL_MASK);
  assign pack_ov = |(alarm_word[LVL_PACK_OV +: 2] & LVL_MASK);
  assign pack_uv = |(alarm_word[LVL_PACK_UV +: 2] & LVL_MASK);
  assign dis_oc  = |(alarm_word[LVL_DIS_OC  +: 2] & LVL_MASK);
  assign chg_oc  = |(alarm_word[LVL_CHG_OC  +: 2] & LVL_MASK);
  assign over_t  = |(alarm_word[LVL_OVER_T  +: 2] & LVL_MASK);
  assign under_t = |(alarm_word[LVL_UNDER_T +: 2] & LVL_MASK);

  assign chg_block = chg_oc || over_t || pack_ov || cell_ov;
  assign dis_block = dis_oc || under_t || pack_uv || cell_uv;

  always_comb begin
    ev_c             = '0;
    ev_c[EV_OV]      = cell_ov || pack_ov;
    ev_c[EV_UV]      = cell_uv || pack_uv;
    ev_c[EV_OVER_T]  = over_t;
    ev_c[EV_UNDER_T] = under_t;
    ev_c[EV_CHG_OC]  = chg_oc;
    ev_c[EV_DIS_OC]  = dis_oc;
  end

  // Percent to hundredths of a percent.
  assign soc_pptt_c = SOC_PPTT_W'(soc_pct) * SOC_PPTT_W'(PCT_TO_PPTT);

  // Whether the ramp division is needed for the charge limit.
  always_ff @(posedge clk) begin
    if (rst) begin
      need_ramp <= 1'b0;
    end else if (cmd.prep) begin
      need_ramp <= !chg_block && (soc_pptt_c <= {1'b0, TOP_SOC})
                   && (soc_pptt_c > {1'b0, rampdown_soc_pptt});
    end
  end

  // Shared multiplier: charge percent times capacity, or override times headroom.
  assign mul_a = cmd.mul_ramp ? charge_power_override_w : capacity_wh;
  assign mul_b = cmd.mul_ramp ? ({1'b0, FULL_PPTT} - soc_work) : SOC_PPTT_W'(soc_pct);
  assign mul_p = DIV_W'(mul_a) * DIV_W'(mul_b);

  // Division of the percent-capacity product by one hundred through its reciprocal.
  assign rem_scaled = REM_MUL_W'(div_acc[REM_PROD_W-1:0]) * REM_MUL_W'(RECIP_100);

  // One restoring division step.
  assign trial      = {div_part, div_acc[DIV_W-1]};
  assign trial_ge   = (trial >= {1'b0, divisor});
  assign trial_diff = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.mul_rem || cmd.mul_ramp) begin
      div_acc  <= mul_p;
      div_part <= '0;
      divisor  <= FULL_PPTT - rampdown_soc_pptt;
    end else if (cmd.div_step) begin
      div_part <= trial_ge ? trial_diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
      div_acc  <= {div_acc[DIV_W-2:0], trial_ge};
    end
  end

  // Working result registers.
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      soc_work <= soc_pptt_c;
      if (chg_block) begin
        charge_work <= '0;
      end else if (soc_pptt_c > {1'b0, TOP_SOC}) begin
        charge_work <= top_balance_power_w;
      end else begin
        charge_work <= charge_power_override_w;
      end
    end else if (cmd.store_ramp) begin
      charge_work <= div_acc[PWR_W-1:0];
    end
    if (cmd.store_rem) begin
      remaining_work <= rem_scaled[RECIP_SHIFT +: REM_W];
    end
  end

  // Output register, loaded when the controller publishes a result.
  assign cur_neg = -$signed({pack_current[15], pack_current});

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      soc_pptt          <= soc_work;
      remaining_wh      <= remaining_work;
      pack_volt_dv      <= pack_voltage;
      pack_cur_da       <= cur_neg;
      charge_limit_w    <= charge_work;
      discharge_limit_w <= dis_block ? '0 : discharge_power_override_w;
      temp_max_dc       <= temp_high;
      temp_min_dc       <= temp_low;
      cell_max_mv       <= cell_high_mv;
      cell_min_mv       <= cell_low_mv;
      fault             <= |alarm_word;
      event_flags       <= ev_c;
    end
  end

endmodule

>>> design/bcsd_checker.sv
// Port-level assertion checker for the battery status decoder, with its bind.
`include "bms_can_status_decoder_top_defines.svh"

module bcsd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           frame_valid,
  input logic                           frame_ready,
  input logic                           status_valid,
  input logic                           status_ready,
  input logic [bcsd_pkg::REM_W-1:0]     status_remaining_wh,
  input logic [bcsd_pkg::PWR_W-1:0]     status_discharge_limit_w,
  input logic                           status_fault,
  input logic [bcsd_pkg::EV_W-1:0]      status_event_flags
);
  import bcsd_pkg::*;

  // Frames are worked on one at a time: an accepted frame closes the input.
  `BCSD_ASSERT_NEXT(a_one_frame_at_a_time, frame_valid && frame_ready, !frame_ready, "frame accepted while busy")

  // A result that is not taken stays offered, with its remaining energy unchanged.
  `BCSD_ASSERT_NEXT(a_result_held, status_valid && !status_ready, status_valid && $stable(status_remaining_wh), "result dropped or changed while stalled")

  // No result is offered right after reset.
  `BCSD_ASSERT_NOW(a_empty_after_reset, $past(rst), !status_valid, "result offered after reset")

  // Any event flag implies a nonzero alarm word.
  `BCSD_ASSERT_NOW(a_fault_covers_events, status_valid && (status_event_flags != '0), status_fault, "event flag without fault")

  // A discharge-side alarm blocks discharge.
  `BCSD_ASSERT_NOW(a_discharge_blocked, status_valid && (status_event_flags[EV_UV] || status_event_flags[EV_UNDER_T] || status_event_flags[EV_DIS_OC]), status_discharge_limit_w == '0, "discharge allowed under alarm")

endmodule

bind bms_can_status_decoder_top bcsd_checker u_bcsd_checker (
  .clk                      (clk),
  .rst                      (rst),
  .frame_valid              (frame.valid),
  .frame_ready              (frame.ready),
  .status_valid             (status.valid),
  .status_ready             (status.ready),
  .status_remaining_wh      (status.remaining_wh),
  .status_discharge_limit_w (status.discharge_limit_w),
  .status_fault             (status.fault),
  .status_event_flags       (status.event_flags)
);
